@@ sv/sap_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sap_pkg;

    // Table geometry.
    localparam int MAX_SLOTS = 512;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);

    // Widths of the word fields.
    localparam int SLOT_W    = 9;
    localparam int LIVE_W    = 10;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_PRESENT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_WINDOW   = 2'd3;

    // Item modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result outcome codes.
    localparam logic [1:0] OUT_REUSED    = 2'd0;
    localparam logic [1:0] OUT_APPENDED  = 2'd1;
    localparam logic [1:0] OUT_OVERWROTE = 2'd2;
    localparam logic [1:0] OUT_FREED     = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } sap_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic start;
        logic scan_en;
        logic commit;
    } sap_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic hit;
        logic exhausted;
        logic out_free;
    } sap_stat_t;

endpackage

@@ sv/sap_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences the clearing pass, item intake, slot scan and commit.
// ----------------------------------------------------------------------------
module sap_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sap_pkg::sap_stat_t stat,
    output sap_pkg::sap_cmd_t  cmd
);

    sap_pkg::sap_state_t state_reg;
    sap_pkg::sap_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sap_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            sap_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = sap_pkg::ST_IDLE;
                end
            end
            sap_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = sap_pkg::ST_SCAN;
                end
            end
            sap_pkg::ST_SCAN: begin
                // A free needs no search; an allocate scans until a hit or the end.
                if (stat.is_free) begin
                    state_next = sap_pkg::ST_COMMIT;
                end else begin
                    cmd.scan_en = 1'b1;
                    if (stat.hit || stat.exhausted) begin
                        state_next = sap_pkg::ST_COMMIT;
                    end
                end
            end
            sap_pkg::ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = sap_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sap_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/sap_datapath.sv @@
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Slot tables, live count, configuration registers, scan pipeline and the
// result register.
// ----------------------------------------------------------------------------
module sap_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [sap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sap_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic [sap_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sap_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [1:0]                          m_tuser,
    input  sap_pkg::sap_cmd_t                   cmd,
    output sap_pkg::sap_stat_t                  stat
);

    localparam int AW = sap_pkg::ADDR_W;
    localparam int CW = sap_pkg::COUNT_W;

    // Configuration registers.
    logic [sap_pkg::SLOT_W-1:0] reserved_reg;
    logic                       time_reg;
    logic [sap_pkg::MS_W-1:0]   delay_reg;
    logic [sap_pkg::MS_W-1:0]   early_reg;

    // Item and control registers.
    logic                       item_mode_reg;
    logic [sap_pkg::SLOT_W-1:0] item_idx_reg;
    logic [sap_pkg::TIME_W-1:0] item_now_reg;
    logic [CW-1:0]              count_live_reg, count_live_next;
    logic [AW-1:0]              clr_idx_reg;
    logic [CW-1:0]              issue_idx_reg, issue_idx_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [AW-1:0]              pend_idx_reg, pend_idx_next;
    logic                       found_reg, found_next;
    logic [AW-1:0]              found_idx_reg, found_idx_next;

    // Result register.
    logic                       m_valid_reg, m_valid_next;
    logic [sap_pkg::SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic [1:0]                 m_outcome_reg, m_outcome_next;
    logic [sap_pkg::LIVE_W-1:0] m_live_reg, m_live_next;

    // Slot tables and their read data.
    logic                       flag_mem  [sap_pkg::MAX_SLOTS];
    logic [sap_pkg::TIME_W-1:0] stamp_mem [sap_pkg::MAX_SLOTS];
    logic                       rd_flag_reg;
    logic [sap_pkg::TIME_W-1:0] rd_stamp_reg;

    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       flag_we, flag_wd;
    logic                       stamp_we;
    logic [sap_pkg::TIME_W-1:0] stamp_wd;

    logic                       issue_ok;
    logic                       qualifies;
    logic                       idx_ok;
    logic [AW-1:0]              alloc_slot;
    logic [1:0]                 alloc_outcome;
    logic [CW-1:0]              alloc_count;
    logic [sap_pkg::TIME_W-1:0] age;

    // Configuration writes; the port is always ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
            time_reg     <= 1'b1;
            delay_reg    <= sap_pkg::MS_W'(500);
            early_reg    <= sap_pkg::MS_W'(2000);
        end else if (cfg_valid) begin
            case (cfg_index)
                sap_pkg::CFG_RESERVED_COUNT: reserved_reg <= cfg_data[sap_pkg::SLOT_W-1:0];
                sap_pkg::CFG_TIME_PRESENT:   time_reg     <= cfg_data[0];
                sap_pkg::CFG_REUSE_DELAY:    delay_reg    <= cfg_data;
                sap_pkg::CFG_EARLY_WINDOW:   early_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item capture at intake.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_mode_reg <= s_tuser;
            item_idx_reg  <= s_tdata[sap_pkg::SLOT_W-1:0];
            item_now_reg  <= s_tdata[sap_pkg::SLOT_W +: sap_pkg::TIME_W];
        end
    end

    // Qualification of the slot read in the previous cycle.
    assign age      = item_now_reg - rd_stamp_reg;
    assign qualifies = rd_flag_reg &&
                       (!time_reg ||
                        (rd_stamp_reg < sap_pkg::TIME_W'(early_reg)) ||
                        ((item_now_reg > rd_stamp_reg) &&
                         (age > sap_pkg::TIME_W'(delay_reg))));

    assign issue_ok = issue_idx_reg < count_live_reg;
    assign rd_addr  = issue_idx_reg[AW-1:0];

    // Scan pipeline: issue one read per cycle, test the one issued before.
    always_comb begin
        issue_idx_next  = issue_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        if (cmd.start) begin
            issue_idx_next  = CW'(reserved_reg) + CW'(1);
            pend_valid_next = 1'b0;
            found_next      = 1'b0;
        end else if (cmd.scan_en) begin
            if (issue_ok) begin
                issue_idx_next = issue_idx_reg + CW'(1);
            end
            pend_valid_next = issue_ok;
            pend_idx_next   = rd_addr;
            if (stat.hit) begin
                found_next     = 1'b1;
                found_idx_next = pend_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            issue_idx_reg  <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            issue_idx_reg  <= issue_idx_next;
        end
        pend_idx_reg  <= pend_idx_next;
        found_idx_reg <= found_idx_next;
    end

    // Allocation decision: reuse a found slot, else append, else overwrite the last.
    always_comb begin
        alloc_count = count_live_reg;
        if (found_reg) begin
            alloc_slot    = found_idx_reg;
            alloc_outcome = sap_pkg::OUT_REUSED;
        end else if (count_live_reg >= CW'(sap_pkg::MAX_SLOTS)) begin
            alloc_slot    = AW'(sap_pkg::MAX_SLOTS - 1);
            alloc_outcome = sap_pkg::OUT_OVERWROTE;
        end else begin
            alloc_slot    = count_live_reg[AW-1:0];
            alloc_outcome = sap_pkg::OUT_APPENDED;
            alloc_count   = count_live_reg + CW'(1);
        end
    end

    assign idx_ok = CW'(item_idx_reg) < CW'(sap_pkg::MAX_SLOTS);

    // Table write port: clearing pass, free stamping or allocation.
    always_comb begin
        wr_addr  = clr_idx_reg;
        flag_we  = 1'b0;
        flag_wd  = 1'b0;
        stamp_we = 1'b0;
        stamp_wd = '0;
        if (cmd.clr_step) begin
            flag_we  = 1'b1;
            stamp_we = 1'b1;
        end else if (cmd.commit) begin
            if (item_mode_reg == sap_pkg::MODE_FREE) begin
                wr_addr  = AW'(item_idx_reg);
                flag_we  = idx_ok;
                flag_wd  = 1'b1;
                stamp_we = idx_ok && time_reg;
                stamp_wd = item_now_reg;
            end else begin
                wr_addr  = alloc_slot;
                flag_we  = 1'b1;
            end
        end
    end

    // Slot tables with registered reads.
    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[wr_addr] <= flag_wd;
        end
        if (stamp_we) begin
            stamp_mem[wr_addr] <= stamp_wd;
        end
        rd_flag_reg  <= flag_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    // Clearing pass counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
        end
    end

    // Live count and result register.
    always_comb begin
        count_live_next = count_live_reg;
        m_valid_next    = m_valid_reg;
        m_slot_next     = m_slot_reg;
        m_outcome_next  = m_outcome_reg;
        m_live_next     = m_live_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            m_valid_next = 1'b1;
            if (item_mode_reg == sap_pkg::MODE_FREE) begin
                m_slot_next    = item_idx_reg;
                m_outcome_next = sap_pkg::OUT_FREED;
            end else begin
                count_live_next = alloc_count;
                m_slot_next     = sap_pkg::SLOT_W'(alloc_slot);
                m_outcome_next  = alloc_outcome;
            end
            m_live_next = sap_pkg::LIVE_W'(count_live_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_live_reg <= CW'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            count_live_reg <= count_live_next;
            m_valid_reg    <= m_valid_next;
        end
        m_slot_reg    <= m_slot_next;
        m_outcome_reg <= m_outcome_next;
        m_live_reg    <= m_live_next;
    end

    // Status back to the controller.
    assign stat.clr_done  = clr_idx_reg == AW'(sap_pkg::MAX_SLOTS - 1);
    assign stat.is_free   = item_mode_reg == sap_pkg::MODE_FREE;
    assign stat.hit       = pend_valid_reg && qualifies;
    assign stat.exhausted = !pend_valid_reg && !issue_ok;
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Result word: slot in the low bits, then the live count.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sap_pkg::M_DATA_W'({m_live_reg, m_slot_reg});
    assign m_tuser  = m_outcome_reg;

    // A commit never overwrites a result that has not been taken.
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("commit while result register is occupied");

    // The live count stays within one and the table size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_live_reg != '0) && (count_live_reg <= CW'(sap_pkg::MAX_SLOTS)))
        else $error("live count out of range");

    // A reuse hit always lies inside the live region.
    a_hit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.hit |-> (CW'(pend_idx_reg) < count_live_reg))
        else $error("scan hit beyond the live slots");

    // The live count grows by at most one per commit and never shrinks.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (count_live_reg == $past(count_live_reg)) ||
                       (count_live_reg == $past(count_live_reg) + CW'(1)))
        else $error("live count changed by more than one");

endmodule

@@ sv/slot_allocator_with_reuse_delay_unit.sv @@
// ----------------------------------------------------------------------------
// Slot allocator with reuse delay
// First-fit slot allocator that holds freed slots back for a reuse delay.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_t*: tuser carries the mode (0 allocate, 1 free),
//   tdata carries the slot index and the current time in milliseconds.
//   Each word yields one result word on m_t*: tuser carries the outcome,
//   tdata the slot and the live count after the item.
//   Registers are written on the cfg_* channel; the user must do so only while
//   the block is idle, which the block does not enforce. The channel is always ready.
// Sequencing:
//   One item is processed at a time. A free passes from intake through the
//   scan and commit states to a valid result word; an allocate reads one slot
//   per cycle in the scan state, at most 511 slots, as the tables have a single
//   read port, then commits. The next word is taken in the idle state that
//   follows the commit.
// Reset:
//   After reset a clearing pass writes all 512 table entries, one per
//   cycle; s_tready stays low until the pass is done.
// Stalls:
//   The result sits in an output register; the next input word is accepted
//   while it waits, and that item is held before commit until it is taken.
// ----------------------------------------------------------------------------
module slot_allocator_with_reuse_delay_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sap_pkg::CFG_DAT_W-1:0]  cfg_data,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sap_pkg::S_DATA_W-1:0]   s_tdata,   // slot_index[8:0], now_time[40:9], zero pad
    input  logic                           s_tuser,   // mode[0]
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sap_pkg::M_DATA_W-1:0]   m_tdata,   // slot[8:0], live_count[18:9], zero pad
    output logic [1:0]                     m_tuser    // outcome[1:0]
);

    sap_pkg::sap_cmd_t  cmd;
    sap_pkg::sap_stat_t stat;

    assign cfg_ready = 1'b1;

    // Controller.
    sap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    sap_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
